/* design/pdp_pkg.sv */
// ----------------------------------------------------------------------------
// pdp_pkg
// Types and codes shared by the page delta payload parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pdp_pkg;

  // Configuration register indexes
  localparam logic REG_DELTA_KIND = 1'b0;
  localparam logic REG_IMAGE_KIND = 1'b1;

  localparam logic [7:0] DELTA_KIND_RESET = 8'd1;
  localparam logic [7:0] IMAGE_KIND_RESET = 8'd2;

  // Result kinds
  localparam logic [2:0] RES_DELTA_HDR   = 3'd0;
  localparam logic [2:0] RES_IMAGE_HDR   = 3'd1;
  localparam logic [2:0] RES_DELTA_START = 3'd2;
  localparam logic [2:0] RES_DELTA_BYTE  = 3'd3;
  localparam logic [2:0] RES_IMAGE_BYTE  = 3'd4;
  localparam logic [2:0] RES_UNKNOWN     = 3'd5;
  localparam logic [2:0] RES_TRUNCATED   = 3'd6;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified payload byte waiting for the parser
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
    logic       is_delta;
    logic       is_image;
  } entry_t;

  typedef enum logic [8:0] {
    PH_KIND   = 9'b000000001,
    PH_DPAGE  = 9'b000000010,
    PH_DCOUNT = 9'b000000100,
    PH_DOFF   = 9'b000001000,
    PH_DSIZE  = 9'b000010000,
    PH_DDATA  = 9'b000100000,
    PH_IPAGE  = 9'b001000000,
    PH_IDATA  = 9'b010000000,
    PH_SKIP   = 9'b100000000
  } phase_t;

endpackage

`default_nettype wire

/* design/pdp_in_if.sv */
// ----------------------------------------------------------------------------
// pdp_in_if
// Payload byte channel: one byte and its end-of-payload flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       final_byte;

  modport source (output valid, output payload_byte, output final_byte, input ready);
  modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* design/pdp_out_if.sv */
// ----------------------------------------------------------------------------
// pdp_out_if
// Parser result channel: one decoded result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [63:0] page_number;
  logic [15:0] delta_total;
  logic [15:0] delta_position;
  logic [15:0] delta_length;
  logic [7:0]  data_value;
  logic        payload_end;

  modport source (output valid, output result_kind, output page_number,
                  output delta_total, output delta_position, output delta_length,
                  output data_value, output payload_end, input ready);
  modport sink   (input valid, input result_kind, input page_number,
                  input delta_total, input delta_position, input delta_length,
                  input data_value, input payload_end, output ready);
endinterface

`default_nettype wire

/* design/pdp_front.sv */
// ----------------------------------------------------------------------------
// pdp_front
// Holds the kind code registers, accepts payload bytes and tags each one
// with its kind code matches before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [7:0]    cfg_wdata,
  pdp_in_if.sink             payload,
  input  wire logic          full,
  output logic               push,
  output pdp_pkg::entry_t    push_entry
);

  logic [7:0] delta_kind_code;
  logic [7:0] image_kind_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_kind_code <= pdp_pkg::DELTA_KIND_RESET;
      image_kind_code <= pdp_pkg::IMAGE_KIND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pdp_pkg::REG_DELTA_KIND: delta_kind_code <= cfg_wdata;
        pdp_pkg::REG_IMAGE_KIND: image_kind_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign payload.ready = !full;
  assign push          = payload.valid && !full;

  always_comb begin
    push_entry.payload_byte = payload.payload_byte;
    push_entry.final_byte   = payload.final_byte;
    push_entry.is_delta     = (payload.payload_byte == delta_kind_code);
    push_entry.is_image     = (payload.payload_byte == image_kind_code);
  end

endmodule

`default_nettype wire

/* design/pdp_queue.sv */
// ----------------------------------------------------------------------------
// pdp_queue
// Two-entry queue between the byte front end and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pdp_pkg::entry_t  push_entry,
  output logic                  full,
  output logic                  q_valid,
  output pdp_pkg::entry_t       q_entry,
  input  wire logic             pop
);

  localparam int unsigned PtrW = $clog2(pdp_pkg::QUEUE_DEPTH);

  pdp_pkg::entry_t    mem [pdp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [PtrW:0]      count;

  assign full    = (count == (PtrW+1)'(pdp_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/pdp_back.sv */
// ----------------------------------------------------------------------------
// pdp_back
// Payload parser: assembles the header and delta fields byte by byte and
// drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire pdp_pkg::entry_t  q_entry,
  output logic                  pop,
  pdp_out_if.source             result
);

  pdp_pkg::phase_t phase, phase_next;
  logic [2:0]      field_cnt, field_cnt_next;
  logic [63:0]     page_acc, page_acc_next;
  logic [15:0]     deltas_left, deltas_left_next;
  logic [15:0]     offset_acc, offset_acc_next;
  logic [15:0]     bytes_left, bytes_left_next;

  logic            emit;
  logic [2:0]      res_kind;
  logic [63:0]     res_page;
  logic [15:0]     res_total;
  logic [15:0]     res_pos;
  logic [15:0]     res_len;
  logic [7:0]      res_data;
  logic            res_end;

  logic [7:0]      b;
  logic [15:0]     deltas_dec;

  logic            out_valid;

  assign b          = q_entry.payload_byte;
  assign pop        = q_valid && (!out_valid || result.ready);
  assign deltas_dec = deltas_left - 16'd1;

  always_comb begin
    phase_next       = phase;
    field_cnt_next   = field_cnt;
    page_acc_next    = page_acc;
    deltas_left_next = deltas_left;
    offset_acc_next  = offset_acc;
    bytes_left_next  = bytes_left;
    emit      = 1'b0;
    res_kind  = pdp_pkg::RES_DELTA_HDR;
    res_page  = '0;
    res_total = '0;
    res_pos   = '0;
    res_len   = '0;
    res_data  = '0;
    res_end   = 1'b0;

    case (phase)
      pdp_pkg::PH_DPAGE, pdp_pkg::PH_IPAGE: begin
        page_acc_next[{field_cnt, 3'b000} +: 8] = b;
        if (field_cnt == 3'd7) begin
          field_cnt_next = '0;
          if (phase == pdp_pkg::PH_IPAGE) begin
            emit       = 1'b1;
            res_kind   = pdp_pkg::RES_IMAGE_HDR;
            res_page   = page_acc_next;
            phase_next = pdp_pkg::PH_IDATA;
          end else begin
            phase_next = pdp_pkg::PH_DCOUNT;
          end
        end else begin
          field_cnt_next = field_cnt + 3'd1;
        end
      end
      pdp_pkg::PH_DCOUNT: begin
        if (field_cnt == 3'd0) begin
          deltas_left_next = {8'h00, b};
          field_cnt_next   = 3'd1;
        end else begin
          deltas_left_next = {b, deltas_left[7:0]};
          field_cnt_next   = '0;
          emit       = 1'b1;
          res_kind   = pdp_pkg::RES_DELTA_HDR;
          res_page   = page_acc;
          res_total  = deltas_left_next;
          phase_next = (deltas_left_next == '0) ? pdp_pkg::PH_SKIP : pdp_pkg::PH_DOFF;
        end
      end
      pdp_pkg::PH_DOFF: begin
        if (field_cnt == 3'd0) begin
          offset_acc_next = {8'h00, b};
          field_cnt_next  = 3'd1;
        end else begin
          offset_acc_next = {b, offset_acc[7:0]};
          field_cnt_next  = '0;
          phase_next      = pdp_pkg::PH_DSIZE;
        end
      end
      pdp_pkg::PH_DSIZE: begin
        if (field_cnt == 3'd0) begin
          bytes_left_next = {8'h00, b};
          field_cnt_next  = 3'd1;
        end else begin
          bytes_left_next = {b, bytes_left[7:0]};
          field_cnt_next  = '0;
          emit     = 1'b1;
          res_kind = pdp_pkg::RES_DELTA_START;
          res_pos  = offset_acc;
          res_len  = bytes_left_next;
          if (bytes_left_next == '0) begin
            // empty delta: close it now
            deltas_left_next = deltas_dec;
            phase_next = (deltas_dec == '0) ? pdp_pkg::PH_SKIP : pdp_pkg::PH_DOFF;
          end else begin
            phase_next = pdp_pkg::PH_DDATA;
          end
        end
      end
      pdp_pkg::PH_DDATA: begin
        emit            = 1'b1;
        res_kind        = pdp_pkg::RES_DELTA_BYTE;
        res_data        = b;
        bytes_left_next = bytes_left - 16'd1;
        if (bytes_left_next == '0) begin
          deltas_left_next = deltas_dec;
          field_cnt_next   = '0;
          phase_next = (deltas_dec == '0) ? pdp_pkg::PH_SKIP : pdp_pkg::PH_DOFF;
        end
      end
      pdp_pkg::PH_IDATA: begin
        emit     = 1'b1;
        res_kind = pdp_pkg::RES_IMAGE_BYTE;
        res_data = b;
      end
      pdp_pkg::PH_SKIP: begin
      end
      default: begin
        // kind byte; delta wins when both codes match
        field_cnt_next = '0;
        page_acc_next  = '0;
        if (q_entry.is_delta) begin
          phase_next = pdp_pkg::PH_DPAGE;
        end else if (q_entry.is_image) begin
          phase_next = pdp_pkg::PH_IPAGE;
        end else begin
          emit       = 1'b1;
          res_kind   = pdp_pkg::RES_UNKNOWN;
          phase_next = pdp_pkg::PH_SKIP;
        end
      end
    endcase

    if (q_entry.final_byte) begin
      if (phase_next != pdp_pkg::PH_SKIP && phase_next != pdp_pkg::PH_IDATA) begin
        // ended inside a field or with deltas still owed
        emit      = 1'b1;
        res_kind  = pdp_pkg::RES_TRUNCATED;
        res_page  = '0;
        res_total = '0;
        res_pos   = '0;
        res_len   = '0;
        res_data  = '0;
      end
      res_end          = emit;
      phase_next       = pdp_pkg::PH_KIND;
      field_cnt_next   = '0;
      page_acc_next    = '0;
      deltas_left_next = '0;
      offset_acc_next  = '0;
      bytes_left_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pdp_pkg::PH_KIND;
      field_cnt   <= '0;
      page_acc    <= '0;
      deltas_left <= '0;
      offset_acc  <= '0;
      bytes_left  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        field_cnt   <= field_cnt_next;
        page_acc    <= page_acc_next;
        deltas_left <= deltas_left_next;
        offset_acc  <= offset_acc_next;
        bytes_left  <= bytes_left_next;
        out_valid   <= emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register: load only when a new result is issued
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      result.result_kind    <= res_kind;
      result.page_number    <= res_page;
      result.delta_total    <= res_total;
      result.delta_position <= res_pos;
      result.delta_length   <= res_len;
      result.data_value     <= res_data;
      result.payload_end    <= res_end;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

/* design/page_delta_payload_parser.sv */
// ----------------------------------------------------------------------------
// page_delta_payload_parser
// Log payload parser: splits delta and full-image payloads into headers,
// delta starts and data bytes, and flags unknown kinds and truncation.
//
//   channel   dir  beat contents
//   payload   in   payload_byte, final_byte
//   result    out  result_kind, page_number, delta_total, delta_position,
//                  delta_length, data_value, payload_end
//   cfg       in   cfg_we, cfg_index, cfg_wdata (kind codes, write only)
//
// One byte per cycle sustained while results are taken; at most one result per
// byte, registered after its byte is accepted (queue write at acceptance, then
// parser state and result register when the parser pops the byte).
// The parser state register sets the rate: each popped byte updates it once.
// Synchronous reset clears the queue, parser state and result valid, and
// restores the kind codes to delta 1, image 2.
// A stalled result holds in its register; the two-entry queue keeps taking
// bytes until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module page_delta_payload_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  pdp_in_if.sink          payload,
  pdp_out_if.source       result
);

  logic             push;
  logic             full;
  logic             q_valid;
  logic             pop;
  pdp_pkg::entry_t  push_entry;
  pdp_pkg::entry_t  q_entry;

  pdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .payload    (payload),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  pdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (pop)
  );

  pdp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire
